[hw/rtl/f1s_pkg.sv]
// f1s_pkg: shared types and constants for the macro F1 score unit.
// No dependencies; imported by every module under hw/rtl.

package f1s_pkg;

    localparam int LABEL_W   = 4;    // class label width on the input beat
    localparam int FRAC_BITS = 16;   // fraction bits of a score
    localparam int SCORE_W   = 17;   // score width, 1.0 = 2**FRAC_BITS
    localparam int STEP_W    = 5;    // holds SCORE_W divider steps

    typedef enum logic [2:0] {
        ST_RUN,
        ST_DRAIN,
        ST_READ,
        ST_LOAD,
        ST_DIV,
        ST_ACC,
        ST_DONE
    } t_f1s_state;

    // control from the sequencer to the counter memories
    typedef struct packed {
        logic acc;      // input beat accepted this cycle
        logic walk;     // read address comes from the class walk
        logic clear;    // drop all counts and the overflow flag
    } t_f1s_mem_ctl;

endpackage

[hw/rtl/f1s_cnt_mem.sv]
// f1s_cnt_mem: per-class tp/fn and fp counter memories with read-modify-write
// update, one-deep write forwarding, saturation and per-entry valid bits.
// Depends on f1s_pkg.

module f1s_cnt_mem import f1s_pkg::*; #(
    parameter int CLASS_COUNT  = 16,
    parameter int COUNTER_BITS = 16,
    parameter int IDX_W        = 4
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_f1s_mem_ctl            i_ctl,
    input  logic [LABEL_W-1:0]      i_true_label,
    input  logic [LABEL_W-1:0]      i_pred_label,
    input  logic [IDX_W-1:0]        i_walk_addr,
    output logic [COUNTER_BITS-1:0] o_tp,
    output logic [COUNTER_BITS-1:0] o_fp,
    output logic [COUNTER_BITS-1:0] o_fn,
    output logic                    o_ovf
);

    localparam int CB = COUNTER_BITS;
    localparam logic [CB-1:0] CNT_MAX = '1;

    // memory A holds {tp, fn} indexed by the true label, memory B holds fp
    logic [2*CB-1:0]        r_mem_a [CLASS_COUNT];
    logic [CB-1:0]          r_mem_b [CLASS_COUNT];
    logic [CLASS_COUNT-1:0] r_vld_a;
    logic [CLASS_COUNT-1:0] r_vld_b;

    logic [2*CB-1:0] r_rd_a;
    logic            r_rd_a_vld;
    logic [CB-1:0]   r_rd_b;
    logic            r_rd_b_vld;

    logic             r_s1_vld;
    logic             r_s1_tp;
    logic             r_s1_fn;
    logic             r_s1_fp;
    logic [IDX_W-1:0] r_s1_a;
    logic [IDX_W-1:0] r_s1_b;

    logic             r_fw_a_vld;
    logic [IDX_W-1:0] r_fw_a_addr;
    logic [2*CB-1:0]  r_fw_a_data;
    logic             r_fw_b_vld;
    logic [IDX_W-1:0] r_fw_b_addr;
    logic [CB-1:0]    r_fw_b_data;

    logic r_ovf;

    logic [IDX_W+LABEL_W-1:0] t_ext;
    logic [IDX_W+LABEL_W-1:0] p_ext;
    logic [IDX_W-1:0]         t_idx;
    logic [IDX_W-1:0]         p_idx;
    logic                     t_ok;
    logic                     p_ok;
    logic [IDX_W-1:0]         rd_addr_a;
    logic [IDX_W-1:0]         rd_addr_b;

    logic [2*CB-1:0] cur_a;
    logic [CB-1:0]   cur_b;
    logic [CB-1:0]   cur_tp;
    logic [CB-1:0]   cur_fn;
    logic [CB-1:0]   n_tp;
    logic [CB-1:0]   n_fn;
    logic [CB-1:0]   n_fp;
    logic [2*CB-1:0] n_a;
    logic            we_a;
    logic            we_b;
    logic            sat_hit;

    assign t_ext     = {{IDX_W{1'b0}}, i_true_label};
    assign p_ext     = {{IDX_W{1'b0}}, i_pred_label};
    assign t_idx     = t_ext[IDX_W-1:0];
    assign p_idx     = p_ext[IDX_W-1:0];
    assign t_ok      = 32'(i_true_label) < CLASS_COUNT;
    assign p_ok      = 32'(i_pred_label) < CLASS_COUNT;
    assign rd_addr_a = i_ctl.walk ? i_walk_addr : t_idx;
    assign rd_addr_b = i_ctl.walk ? i_walk_addr : p_idx;

    always_comb begin
        if (r_fw_a_vld && (r_fw_a_addr == r_s1_a)) begin
            cur_a = r_fw_a_data;
        end else begin
            cur_a = r_rd_a_vld ? r_rd_a : '0;
        end
        if (r_fw_b_vld && (r_fw_b_addr == r_s1_b)) begin
            cur_b = r_fw_b_data;
        end else begin
            cur_b = r_rd_b_vld ? r_rd_b : '0;
        end
        cur_tp = cur_a[2*CB-1:CB];
        cur_fn = cur_a[CB-1:0];
        n_tp   = cur_tp;
        n_fn   = cur_fn;
        n_fp   = cur_b;
        if (r_s1_tp && (cur_tp != CNT_MAX)) begin
            n_tp = cur_tp + CB'(1);
        end
        if (r_s1_fn && (cur_fn != CNT_MAX)) begin
            n_fn = cur_fn + CB'(1);
        end
        if (r_s1_fp && (cur_b != CNT_MAX)) begin
            n_fp = cur_b + CB'(1);
        end
        n_a     = {n_tp, n_fn};
        we_a    = r_s1_vld && (r_s1_tp || r_s1_fn);
        we_b    = r_s1_vld && r_s1_fp;
        sat_hit = r_s1_vld && ((r_s1_tp && (cur_tp == CNT_MAX)) ||
                               (r_s1_fn && (cur_fn == CNT_MAX)) ||
                               (r_s1_fp && (cur_b == CNT_MAX)));
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (we_a) begin
            r_mem_a[r_s1_a] <= n_a;
        end
        if (we_b) begin
            r_mem_b[r_s1_b] <= n_fp;
        end
        r_rd_a     <= r_mem_a[rd_addr_a];
        r_rd_b     <= r_mem_b[rd_addr_b];
        r_rd_a_vld <= r_vld_a[rd_addr_a];
        r_rd_b_vld <= r_vld_b[rd_addr_b];
    end

    // update stage payload
    always_ff @(posedge i_clk) begin
        r_s1_tp     <= (i_true_label == i_pred_label) && t_ok;
        r_s1_fn     <= (i_true_label != i_pred_label) && t_ok;
        r_s1_fp     <= (i_true_label != i_pred_label) && p_ok;
        r_s1_a      <= t_idx;
        r_s1_b      <= p_idx;
        if (we_a) begin
            r_fw_a_addr <= r_s1_a;
            r_fw_a_data <= n_a;
        end
        if (we_b) begin
            r_fw_b_addr <= r_s1_b;
            r_fw_b_data <= n_fp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld   <= 1'b0;
            r_vld_a    <= '0;
            r_vld_b    <= '0;
            r_fw_a_vld <= 1'b0;
            r_fw_b_vld <= 1'b0;
            r_ovf      <= 1'b0;
        end else begin
            r_s1_vld <= i_ctl.acc;
            if (i_ctl.clear) begin
                r_vld_a    <= '0;
                r_vld_b    <= '0;
                r_fw_a_vld <= 1'b0;
                r_fw_b_vld <= 1'b0;
                r_ovf      <= 1'b0;
            end else begin
                if (we_a) begin
                    r_vld_a[r_s1_a] <= 1'b1;
                    r_fw_a_vld      <= 1'b1;
                end
                if (we_b) begin
                    r_vld_b[r_s1_b] <= 1'b1;
                    r_fw_b_vld      <= 1'b1;
                end
                if (sat_hit) begin
                    r_ovf <= 1'b1;
                end
            end
        end
    end

    assign o_tp  = r_rd_a_vld ? r_rd_a[2*CB-1:CB] : '0;
    assign o_fn  = r_rd_a_vld ? r_rd_a[CB-1:0] : '0;
    assign o_fp  = r_rd_b_vld ? r_rd_b : '0;
    assign o_ovf = r_ovf;

endmodule

[hw/rtl/f1s_div.sv]
// f1s_div: radix-2 restoring divider, one quotient bit per cycle, for
// quotients known to fit SCORE_W bits. Depends on f1s_pkg.

module f1s_div import f1s_pkg::*; #(
    parameter int NUM_W = 33,
    parameter int DEN_W = 18
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [NUM_W-1:0]   i_num,
    input  logic [DEN_W-1:0]   i_den,
    output logic               o_done,
    output logic [SCORE_W-1:0] o_quot
);

    logic [DEN_W-1:0]   r_rem;
    logic [DEN_W-1:0]   r_den;
    logic [SCORE_W-1:0] r_q;
    logic [STEP_W-1:0]  r_cnt;
    logic               r_done;

    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;
    logic [DEN_W-1:0] n_rem;

    assign trial = {r_rem, r_q[SCORE_W-1]};
    assign diff  = trial - {1'b0, r_den};
    assign ge    = trial >= {1'b0, r_den};
    assign n_rem = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= DEN_W'(i_num >> SCORE_W);
            r_q   <= i_num[SCORE_W-1:0];
            r_den <= i_den;
        end else if (r_cnt != '0) begin
            r_rem <= n_rem;
            r_q   <= {r_q[SCORE_W-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == STEP_W'(1)) && !i_start;
            if (i_start) begin
                r_cnt <= STEP_W'(SCORE_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - STEP_W'(1);
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

[hw/rtl/macro_f1_score_unit.sv]
// macro_f1_score_unit: macro-averaged F1 over sets of (true, predicted) labels.
// Depends on f1s_pkg, f1s_cnt_mem, f1s_div.
//
//   port group     dir  beat contents
//   s_t*           in   tdata[3:0] true_label, [7:4] predicted_label; tlast last_item
//   m_t*           out  tdata[16:0] average_f1, [33:17] class_f1; tuser count_overflow
//   i/o_cfg_*      in   data[3:0] focus_class, always ready
//
// Labels are taken one beat per cycle while no scoring walk is under way; a counter
// update is a read-modify-write of the counter memories with forwarding between
// back-to-back beats. After the last beat of a set, input stalls for the scoring
// walk: a drain state, then per class read, load, serial divide and accumulate
// (the divide is skipped for an absent class), then a hand-off state.
// The average is a reciprocal multiply taken in the hand-off cycle.
// Synchronous reset clears all counts; no clearing pass is needed.
// A waiting result stalls input only once the next set's result is ready.

module macro_f1_score_unit import f1s_pkg::*; #(
    parameter int CLASS_COUNT  = 16,
    parameter int COUNTER_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [3:0] true_label, [7:4] predicted_label
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [16:0] average_f1, [33:17] class_f1, zeros
    output logic        m_tuser,   // [0] count_overflow
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [3:0]  i_cfg_data // [3:0] focus_class
);

    localparam int IDX_W = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;
    localparam int CB    = COUNTER_BITS;
    localparam int NUM_W = CB + 1 + FRAC_BITS;
    localparam int DEN_W = CB + 2;
    localparam int SUM_W = SCORE_W + IDX_W;
    localparam int PRD_W = 2 * SUM_W + 1;
    // floor(sum / CLASS_COUNT) as (sum * AVG_M) >> AVG_S, exact for sum < 2**SUM_W
    localparam int AVG_S = SUM_W + IDX_W;
    localparam logic [SUM_W:0] AVG_M =
        (SUM_W + 1)'((64'd1 << AVG_S) / 64'(CLASS_COUNT) + 64'd1);

    t_f1s_state r_state;
    t_f1s_state n_state;

    logic [LABEL_W-1:0] r_target;
    logic [IDX_W-1:0]   r_cls;
    logic [SUM_W-1:0]   r_sum;
    logic [SCORE_W-1:0] r_cls_f1;
    logic               r_zero;

    logic               r_m_tvalid;
    logic [SCORE_W-1:0] r_m_avg;
    logic [SCORE_W-1:0] r_m_cls;
    logic               r_m_ovf;

    t_f1s_mem_ctl mem_ctl;
    logic         s_acc;
    logic         div_start;
    logic         out_load;
    logic         last_cls;

    logic [CB-1:0]      tp;
    logic [CB-1:0]      fp;
    logic [CB-1:0]      fn;
    logic               ovf;
    logic [DEN_W-1:0]   den;
    logic [NUM_W-1:0]   div_num;
    logic [DEN_W-1:0]   div_den;
    logic               div_done;
    logic [SCORE_W-1:0] div_quot;
    logic [SCORE_W-1:0] score;
    logic [PRD_W-1:0]   avg_prod;
    logic [SCORE_W-1:0] avg_f1;

    assign s_acc    = s_tvalid && s_tready;
    assign last_cls = r_cls == IDX_W'(CLASS_COUNT - 1);
    assign den      = DEN_W'({tp, 1'b0}) + DEN_W'(fp) + DEN_W'(fn);
    assign score    = r_zero ? '0 : div_quot;
    assign div_num  = {tp, 1'b0, {FRAC_BITS{1'b0}}};
    assign div_den  = den;
    assign avg_prod = PRD_W'(r_sum) * PRD_W'(AVG_M);
    assign avg_f1   = avg_prod[AVG_S +: SCORE_W];

    f1s_cnt_mem #(
        .CLASS_COUNT (CLASS_COUNT),
        .COUNTER_BITS(COUNTER_BITS),
        .IDX_W       (IDX_W)
    ) u_cnt_mem (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (mem_ctl),
        .i_true_label(s_tdata[3:0]),
        .i_pred_label(s_tdata[7:4]),
        .i_walk_addr (r_cls),
        .o_tp        (tp),
        .o_fp        (fp),
        .o_fn        (fn),
        .o_ovf       (ovf)
    );

    f1s_div #(
        .NUM_W(NUM_W),
        .DEN_W(DEN_W)
    ) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(div_start),
        .i_num  (div_num),
        .i_den  (div_den),
        .o_done (div_done),
        .o_quot (div_quot)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_RUN: begin
                if (s_acc && s_tlast) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: n_state = ST_READ;
            ST_READ:  n_state = ST_LOAD;
            ST_LOAD:  n_state = (den == '0) ? ST_ACC : ST_DIV;
            ST_DIV: begin
                if (div_done) begin
                    n_state = ST_ACC;
                end
            end
            ST_ACC:   n_state = last_cls ? ST_DONE : ST_READ;
            ST_DONE: begin
                if (out_load) begin
                    n_state = ST_RUN;
                end
            end
            default:  n_state = ST_RUN;
        endcase
    end

    // state outputs
    always_comb begin
        s_tready      = 1'b0;
        div_start     = 1'b0;
        out_load      = 1'b0;
        mem_ctl.walk  = 1'b1;
        mem_ctl.clear = 1'b0;
        unique case (r_state)
            ST_RUN: begin
                s_tready     = 1'b1;
                mem_ctl.walk = 1'b0;
            end
            ST_LOAD:  div_start = den != '0;
            ST_DONE: begin
                out_load      = !r_m_tvalid || m_tready;
                mem_ctl.clear = !r_m_tvalid || m_tready;
            end
            default: ;
        endcase
        mem_ctl.acc = s_acc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_RUN;
            r_target   <= '0;
            r_m_tvalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_target <= i_cfg_data;
            end
            if (out_load) begin
                r_m_tvalid <= 1'b1;
            end else if (m_tready) begin
                r_m_tvalid <= 1'b0;
            end
        end
    end

    // walk datapath
    always_ff @(posedge i_clk) begin
        if (r_state == ST_DRAIN) begin
            r_cls    <= '0;
            r_sum    <= '0;
            r_cls_f1 <= '0;
        end
        if (r_state == ST_LOAD) begin
            r_zero <= den == '0;
        end
        if (r_state == ST_ACC) begin
            r_sum <= r_sum + SUM_W'(score);
            if (32'(r_cls) == 32'(r_target)) begin
                r_cls_f1 <= score;
            end
            if (!last_cls) begin
                r_cls <= r_cls + IDX_W'(1);
            end
        end
        if (out_load) begin
            r_m_avg <= avg_f1;
            r_m_cls <= r_cls_f1;
            r_m_ovf <= ovf;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign m_tvalid    = r_m_tvalid;
    assign m_tdata     = {6'b0, r_m_cls, r_m_avg};
    assign m_tuser     = r_m_ovf;

endmodule
